### hdl/u8dec_pkg.sv
// Shared types and constants for the strict UTF-8 stream decoder.
package u8dec_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int POINT_WIDTH     = 21;
   localparam int OUT_COUNT_WIDTH = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int RSP_DATA_WIDTH  = 64;

   localparam logic [POINT_WIDTH-1:0] TWO_BYTE_MIN   = 21'h00_0080;
   localparam logic [POINT_WIDTH-1:0] THREE_BYTE_MIN = 21'h00_0800;
   localparam logic [POINT_WIDTH-1:0] SURROGATE_LO   = 21'h00_D800;
   localparam logic [POINT_WIDTH-1:0] SURROGATE_HI   = 21'h00_DFFF;
   localparam logic [POINT_WIDTH-1:0] FOUR_BYTE_MIN  = 21'h01_0000;
   localparam logic [POINT_WIDTH-1:0] SCALAR_MAX     = 21'h10_FFFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEAD  = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_BAD_CONT  = 3'd3,
      ST_OVERLONG  = 3'd4,
      ST_SURROGATE = 3'd5,
      ST_INVALID   = 3'd6
   } status_type;

   typedef struct packed {
      logic [POINT_WIDTH-1:0]     code_point;
      logic                       point_valid;
      status_type                 status;
      logic                       end_of_text;
      logic [OUT_COUNT_WIDTH-1:0] point_count;
   } rsp_type;

endpackage

### hdl/strict_utf8_stream_decoder.sv
// Top level of the strict UTF-8 stream decoder.
//
//  channel | dir | tdata (low bit up)                                  | tlast
//  req     | in  | text_byte[7:0]                                      | last_byte
//  rsp     | out | code_point, point_valid, status, point_count, zeros | end_of_text
//
//  One request per cycle unless stalled; each request is decoded in the cycle it is accepted
//  and its response, if any, appears in the result register on the next cycle.
//  Bytes inside a sequence or after an error give no response, unless they are the final byte.
//  Throughput is set by the single result register: a stalled response blocks
//  req_tready only while rsp_tready is low.
//  Reset (synchronous) clears all decode state and the point counter.
module strict_utf8_stream_decoder
   import u8dec_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_WIDTH-1:0]     req_tdata,   // text_byte
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // code_point, point_valid, status, point_count
   output logic                      rsp_tlast
);

   logic    step;
   logic    result_present;
   rsp_type result;
   rsp_type held;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign step       = req_tvalid && req_tready;

   u8dec_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .text_byte      (req_tdata),
      .last_byte      (req_tlast),
      .result_present (result_present),
      .result         (result)
   );

   u8dec_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && result_present),
      .load_data (result),
      .take      (rsp_tready),
      .full      (rsp_tvalid),
      .data      (held)
   );

   assign rsp_tdata = {7'd0, held.point_count, held.status, held.point_valid,
                       held.code_point};
   assign rsp_tlast = held.end_of_text;

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_point_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && held.point_valid |-> held.status == ST_OK)
      else $error("decoded point carries an error status");

endmodule

### hdl/u8dec_core.sv
// Per-byte decode state, sequence assembly, error checks and point counter.
module u8dec_core
   import u8dec_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [BYTE_WIDTH-1:0] text_byte,
   input  logic                  last_byte,
   output logic                  result_present,
   output rsp_type               result
);

   logic [1:0]             needed_ff, needed_in;
   logic [1:0]             seen_ff, seen_in;
   logic [POINT_WIDTH-1:0] partial_ff, partial_in;
   logic                   badc_ff, badc_in;
   logic                   err_ff, err_in;
   status_type             code_ff, code_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   do_finish;
   logic                   do_error;
   status_type             err_code;
   logic [POINT_WIDTH-1:0] point;
   logic [1:0]             seen_next;
   logic                   badc_next;
   logic [POINT_WIDTH-1:0] partial_next;
   logic [COUNT_WIDTH-1:0] count_sat;
   logic [COUNT_WIDTH-1:0] count_shown;
   logic [OUT_COUNT_WIDTH-1:0] count_clamped;

   assign seen_next    = seen_ff + 2'd1;
   assign badc_next    = badc_ff | (text_byte[7:6] != 2'b10);
   assign partial_next = {partial_ff[POINT_WIDTH-7:0], text_byte[5:0]};
   assign count_sat    = (count_ff == {COUNT_WIDTH{1'b1}}) ? count_ff
                                                           : count_ff + 1'b1;
   assign count_shown  = do_finish ? count_sat : count_ff;

   generate
      if (COUNT_WIDTH > OUT_COUNT_WIDTH) begin : g_clamp
         assign count_clamped = (|count_shown[COUNT_WIDTH-1:OUT_COUNT_WIDTH])
                                ? {OUT_COUNT_WIDTH{1'b1}}
                                : count_shown[OUT_COUNT_WIDTH-1:0];
      end else begin : g_extend
         assign count_clamped = OUT_COUNT_WIDTH'(count_shown);
      end
   endgenerate

   always_comb begin
      do_finish  = 1'b0;
      do_error   = 1'b0;
      err_code   = ST_OK;
      point      = '0;
      needed_in  = needed_ff;
      seen_in    = seen_ff;
      partial_in = partial_ff;
      badc_in    = badc_ff;
      if (err_ff) begin
         do_error = last_byte;
         err_code = code_ff;
      end else if (needed_ff == 2'd0) begin
         if (!text_byte[7]) begin
            do_finish = 1'b1;
            point     = POINT_WIDTH'(text_byte);
         end else if (text_byte[7:5] == 3'b110 || text_byte[7:4] == 4'b1110 ||
                      text_byte[7:3] == 5'b11110) begin
            seen_in = 2'd0;
            badc_in = 1'b0;
            if (text_byte[7:5] == 3'b110) begin
               needed_in  = 2'd1;
               partial_in = POINT_WIDTH'(text_byte[4:0]);
            end else if (text_byte[7:4] == 4'b1110) begin
               needed_in  = 2'd2;
               partial_in = POINT_WIDTH'(text_byte[3:0]);
            end else begin
               needed_in  = 2'd3;
               partial_in = POINT_WIDTH'(text_byte[2:0]);
            end
            if (last_byte) begin
               do_error = 1'b1;
               err_code = ST_TRUNCATED;
            end
         end else begin
            do_error = 1'b1;
            err_code = ST_BAD_LEAD;
         end
      end else begin
         seen_in    = seen_next;
         badc_in    = badc_next;
         partial_in = partial_next;
         point      = partial_next;
         if (seen_next != needed_ff) begin
            if (last_byte) begin
               do_error = 1'b1;
               err_code = ST_TRUNCATED;
            end
         end else if (badc_next) begin
            do_error = 1'b1;
            err_code = ST_BAD_CONT;
         end else if (needed_ff == 2'd1) begin
            if (partial_next < TWO_BYTE_MIN) begin
               do_error = 1'b1;
               err_code = ST_OVERLONG;
            end else begin
               do_finish = 1'b1;
            end
         end else if (needed_ff == 2'd2) begin
            if (partial_next < THREE_BYTE_MIN) begin
               do_error = 1'b1;
               err_code = ST_OVERLONG;
            end else if (partial_next >= SURROGATE_LO && partial_next <= SURROGATE_HI) begin
               do_error = 1'b1;
               err_code = ST_SURROGATE;
            end else begin
               do_finish = 1'b1;
            end
         end else begin
            if (partial_next < FOUR_BYTE_MIN || partial_next > SCALAR_MAX) begin
               do_error = 1'b1;
               err_code = ST_INVALID;
            end else begin
               do_finish = 1'b1;
            end
         end
      end

      err_in   = err_ff;
      code_in  = code_ff;
      count_in = count_ff;
      if (do_error || do_finish) begin
         needed_in  = 2'd0;
         seen_in    = 2'd0;
         partial_in = '0;
         badc_in    = 1'b0;
      end
      if (do_error) begin
         err_in  = 1'b1;
         code_in = err_code;
      end
      if (do_finish) begin
         count_in = count_sat;
      end
      if ((do_error || do_finish) && last_byte) begin
         err_in   = 1'b0;
         code_in  = ST_OK;
         count_in = '0;
      end

      result_present     = do_error || do_finish;
      result.code_point  = do_finish ? point : '0;
      result.point_valid = do_finish;
      result.status      = do_error ? err_code : ST_OK;
      result.end_of_text = last_byte;
      result.point_count = count_clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff  <= 2'd0;
         seen_ff    <= 2'd0;
         partial_ff <= '0;
         badc_ff    <= 1'b0;
         err_ff     <= 1'b0;
         code_ff    <= ST_OK;
         count_ff   <= '0;
      end else if (step) begin
         needed_ff  <= needed_in;
         seen_ff    <= seen_in;
         partial_ff <= partial_in;
         badc_ff    <= badc_in;
         err_ff     <= err_in;
         code_ff    <= code_in;
         count_ff   <= count_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> !err_ff && needed_ff == 2'd0 && count_ff == '0)
      else $error("state not cleared after final byte");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      err_ff && !(step && last_byte) |=> err_ff && $stable(code_ff))
      else $error("latched error dropped before final byte");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      needed_ff != 2'd0 |-> seen_ff < needed_ff)
      else $error("continuation count passed sequence length");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      needed_ff == 2'd0 |-> seen_ff == 2'd0 && !badc_ff)
      else $error("sequence state left over outside a sequence");

endmodule

### hdl/u8dec_out.sv
// Result register holding one decoded response until the consumer takes it.
module u8dec_out
   import u8dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    take,
   output logic    full,
   output rsp_type data
);

   logic    full_ff, full_in;
   rsp_type data_ff, data_in;

   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (load) begin
         full_in = 1'b1;
         data_in = load_data;
      end else if (take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign full = full_ff;
   assign data = data_ff;

endmodule

### sim/tb.sv
// Self-checking testbench for the strict UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb;
   import u8dec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [BYTE_WIDTH-1:0]     req_tdata;   // text_byte
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;   // code_point, point_valid, status, point_count
   logic                      rsp_tlast;

   logic [1:0]  seq_need;
   logic [1:0]  seq_seen;
   logic [2:0]  seq_len;
   logic [20:0] seq_acc;
   logic        cont_bad;
   logic        err_held;
   status_type  err_status;
   logic [31:0] point_total;

   rsp_type      pending_points[$];
   stim_row_type directed_rows[$];
   logic [7:0]   text_bytes[$];
   int           last_len;
   int           src_idle_pct;
   int           sink_stall_pct;
   int           mismatches;
   int           idle_cycles;
   rsp_type      got_rsp;
   rsp_type      want_rsp;

   strict_utf8_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_decoder();
      seq_need    = '0;
      seq_seen    = '0;
      seq_len     = '0;
      seq_acc     = '0;
      cont_bad    = 1'b0;
      err_held    = 1'b0;
      err_status  = ST_OK;
      point_total = '0;
   endfunction

   function automatic rsp_type make_rsp(input logic [20:0] cp, input logic v,
                                        input status_type st, input logic eot);
      rsp_type r;
      r.code_point  = cp;
      r.point_valid = v;
      r.status      = st;
      r.end_of_text = eot;
      r.point_count = point_total;
      return r;
   endfunction

   function automatic bit fail_seq(input status_type st, input logic l, output rsp_type r);
      err_held   = 1'b1;
      err_status = st;
      seq_need   = '0;
      seq_seen   = '0;
      seq_len    = '0;
      seq_acc    = '0;
      cont_bad   = 1'b0;
      r = make_rsp('0, 1'b0, st, l);
      if (l) clear_decoder();
      return 1'b1;
   endfunction

   function automatic bit emit_point(input logic [20:0] cp, input logic l, output rsp_type r);
      if (point_total != '1) point_total = point_total + 1;
      seq_need = '0;
      seq_seen = '0;
      seq_len  = '0;
      seq_acc  = '0;
      cont_bad = 1'b0;
      r = make_rsp(cp, 1'b1, ST_OK, l);
      if (l) clear_decoder();
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic l, output rsp_type r);
      logic [20:0] cp;
      r = '0;
      if (err_held) begin
         if (!l) return 1'b0;
         r = make_rsp('0, 1'b0, err_status, 1'b1);
         clear_decoder();
         return 1'b1;
      end
      if (seq_need == 2'd0) begin
         if (b[7] == 1'b0) return emit_point({13'd0, b}, l, r);
         if (b[7:5] == 3'b110) begin
            seq_need = 2'd1;
            seq_acc  = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            seq_need = 2'd2;
            seq_acc  = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            seq_need = 2'd3;
            seq_acc  = {18'd0, b[2:0]};
         end else begin
            return fail_seq(ST_BAD_LEAD, l, r);
         end
         seq_len  = {1'b0, seq_need} + 3'd1;
         seq_seen = '0;
         cont_bad = 1'b0;
         if (l) return fail_seq(ST_TRUNCATED, 1'b1, r);
         return 1'b0;
      end
      if (b[7:6] != 2'b10) cont_bad = 1'b1;
      seq_acc  = {seq_acc[14:0], b[5:0]};
      seq_seen = seq_seen + 2'd1;
      if (seq_seen != seq_need) begin
         if (l) return fail_seq(ST_TRUNCATED, 1'b1, r);
         return 1'b0;
      end
      if (cont_bad) return fail_seq(ST_BAD_CONT, l, r);
      cp = seq_acc;
      case (seq_len)
         3'd2: begin
            if (cp < TWO_BYTE_MIN) return fail_seq(ST_OVERLONG, l, r);
         end
         3'd3: begin
            if (cp < THREE_BYTE_MIN) return fail_seq(ST_OVERLONG, l, r);
            if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) return fail_seq(ST_SURROGATE, l, r);
         end
         default: begin
            if (cp < FOUR_BYTE_MIN || cp > SCALAR_MAX) return fail_seq(ST_INVALID, l, r);
         end
      endcase
      return emit_point(cp, l, r);
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                            input rsp_type want);
      rsp_type pred;
      bit      produced;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      produced = decode_byte(b, l, pred);
      if (typed) pending_points = {pending_points, want};
      else if (produced) pending_points = {pending_points, pred};
   endtask

   task automatic add_row(input logic [7:0] b, input logic l);
      stim_row_type row;
      row = '0;
      row.text_byte = b;
      row.last_byte = l;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_typed(input logic [7:0] b, input logic l, input logic [20:0] cp,
                            input logic v, input status_type st, input logic eot,
                            input logic [31:0] cnt);
      stim_row_type row;
      row.text_byte        = b;
      row.last_byte        = l;
      row.typed            = 1'b1;
      row.want.code_point  = cp;
      row.want.point_valid = v;
      row.want.status      = st;
      row.want.end_of_text = eot;
      row.want.point_count = cnt;
      directed_rows = {directed_rows, row};
   endtask

   task automatic push_encoded(input logic [20:0] cp, input int len);
      case (len)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic add_element();
      int          kind;
      int          len;
      int          start;
      int          pos;
      logic [20:0] cp;
      logic [7:0]  b;
      start = text_bytes.size();
      kind  = $urandom_range(0, 99);
      if (kind < 60) begin
         len = $urandom_range(1, 4);
         case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
               cp = 21'($urandom_range('h800, 'hFFFF));
               while (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
                  cp = 21'($urandom_range('h800, 'hFFFF));
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
         endcase
         push_encoded(cp, len);
      end else if (kind < 66) begin
         push_encoded(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (kind < 72) begin
         len = $urandom_range(2, 4);
         if (len == 2) cp = 21'($urandom_range(0, 'h7F));
         else if (len == 3) cp = 21'($urandom_range(0, 'h7FF));
         else cp = 21'($urandom_range(0, 'hFFFF));
         push_encoded(cp, len);
      end else if (kind < 78) begin
         push_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (kind < 84) begin
         len = $urandom_range(2, 4);
         push_encoded(21'($urandom_range(0, 'h1FFFFF)), len);
         pos = text_bytes.size() - $urandom_range(1, len - 1);
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         text_bytes[pos] = b;
      end else if (kind < 90) begin
         if ($urandom_range(0, 1)) append_byte(8'($urandom_range('h80, 'hBF)));
         else append_byte(8'($urandom_range('hF8, 'hFF)));
      end else begin
         append_byte(8'($urandom_range(0, 255)));
      end
      last_len = text_bytes.size() - start;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.code_point  = rsp_tdata[20:0];
         got_rsp.point_valid = rsp_tdata[21];
         got_rsp.status      = status_type'(rsp_tdata[24:22]);
         got_rsp.point_count = rsp_tdata[56:25];
         got_rsp.end_of_text = rsp_tlast;
         if (pending_points.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, got %0h", $time, got_rsp);
            mismatches++;
         end else begin
            want_rsp = pending_points.pop_front();
            check_field("code_point", 32'(want_rsp.code_point), 32'(got_rsp.code_point));
            check_field("point_valid", 32'(want_rsp.point_valid), 32'(got_rsp.point_valid));
            check_field("status", 32'(want_rsp.status), 32'(got_rsp.status));
            check_field("end_of_text", 32'(want_rsp.end_of_text), 32'(got_rsp.end_of_text));
            check_field("point_count", want_rsp.point_count, got_rsp.point_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("strict_utf8_stream_decoder test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sent;
      int n_elem;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      mismatches     = 0;
      idle_cycles    = 0;
      clear_decoder();

      add_typed(8'h00, 1'b0, 21'h00, 1'b1, ST_OK, 1'b0, 32'd1);
      add_typed(8'h7F, 1'b1, 21'h7F, 1'b1, ST_OK, 1'b1, 32'd2);
      add_typed(8'hFF, 1'b0, 21'h0, 1'b0, ST_BAD_LEAD, 1'b0, 32'd0);
      add_typed(8'h41, 1'b1, 21'h0, 1'b0, ST_BAD_LEAD, 1'b1, 32'd0);
      add_row(8'hC0, 1'b0);
      add_typed(8'h80, 1'b1, 21'h0, 1'b0, ST_OVERLONG, 1'b1, 32'd0);
      add_row(8'hE0, 1'b0);
      add_row(8'h80, 1'b0);
      add_typed(8'h80, 1'b1, 21'h0, 1'b0, ST_OVERLONG, 1'b1, 32'd0);
      add_row(8'hED, 1'b0);
      add_row(8'hA0, 1'b0);
      add_typed(8'h80, 1'b1, 21'h0, 1'b0, ST_SURROGATE, 1'b1, 32'd0);
      add_row(8'hF4, 1'b0);
      add_row(8'h90, 1'b0);
      add_row(8'h80, 1'b0);
      add_typed(8'h80, 1'b1, 21'h0, 1'b0, ST_INVALID, 1'b1, 32'd0);
      add_row(8'hE2, 1'b0);
      add_typed(8'h41, 1'b1, 21'h0, 1'b0, ST_TRUNCATED, 1'b1, 32'd0);
      add_row(8'hC3, 1'b0);
      add_typed(8'h41, 1'b0, 21'h0, 1'b0, ST_BAD_CONT, 1'b0, 32'd0);
      add_typed(8'h20, 1'b1, 21'h0, 1'b0, ST_BAD_CONT, 1'b1, 32'd0);
      add_typed(8'hF0, 1'b1, 21'h0, 1'b0, ST_TRUNCATED, 1'b1, 32'd0);
      add_row(8'hF4, 1'b0);
      add_row(8'h8F, 1'b0);
      add_row(8'hBF, 1'b0);
      add_typed(8'hBF, 1'b1, 21'h10FFFF, 1'b1, ST_OK, 1'b1, 32'd1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].text_byte, directed_rows[i].last_byte,
                   directed_rows[i].typed, directed_rows[i].want);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
            default: begin src_idle_pct = 28; sink_stall_pct = 28; end
         endcase
         sent = 0;
         while (sent < 100) begin
            text_bytes.delete();
            n_elem = $urandom_range(1, 6);
            repeat (n_elem) add_element();
            if ($urandom_range(0, 99) < 15 && last_len > 1)
               repeat ($urandom_range(1, last_len - 1)) void'(text_bytes.pop_back());
            foreach (text_bytes[i])
               send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
            sent += text_bytes.size();
         end
         req_tvalid <= 1'b0;
         while (pending_points.size() != 0) @(posedge clock);
      end

      sink_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_points.size() == 0)
         $display("strict_utf8_stream_decoder test passed");
      else
         $display("strict_utf8_stream_decoder test failed");
      $finish;
   end

endmodule
